// ===== rtl/pbd_pkg.sv =====
`default_nettype none
package pbd_pkg;

  localparam int unsigned MaxPixels   = 65536;
  localparam int unsigned MaxChannels = 16;
  localparam int unsigned NumLanes    = 4;
  // effective pixel ceiling, also bounded by the 16-bit start_pixel field
  localparam int unsigned PixCap      = (MaxPixels < 65536) ? MaxPixels : 65536;
  localparam int unsigned ChanLimit   = (MaxChannels < NumLanes) ? MaxChannels : NumLanes;

  localparam int unsigned PosW = 17;
  localparam logic [PosW-1:0] PosMax = '1;
  localparam logic [PosW-1:0] ImagePixelsRst = 17'(65536);

  localparam logic [7:0] HdrNop    = 8'd128;
  localparam logic [8:0] RepeatSub = 9'd257;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_LITERAL = 2'd1,
    PH_REPEAT  = 2'd2
  } parse_phase_e;

  // first field in the highest bits
  typedef struct packed {
    logic       plane_start;
    logic       row_start;
    logic [3:0] channel;
    logic [7:0] data_byte;
  } pbd_item_t;

  typedef struct packed {
    logic [7:0]  run_length;
    logic [15:0] start_pixel;
    logic [1:0]  byte_lane;
    logic [7:0]  value;
  } pbd_desc_t;

  localparam int unsigned DescW  = $bits(pbd_desc_t);
  localparam int unsigned DataOW = ((DescW + 7) / 8) * 8;

  function automatic logic [1:0] lane_of_channel(input logic [1:0] ch);
    logic [1:0] lane;
    case (ch)
      2'd0:    lane = 2'd2;
      2'd1:    lane = 2'd1;
      2'd2:    lane = 2'd0;
      default: lane = 2'd3;
    endcase
    return lane;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/pbd_parser.sv =====
`default_nettype none
module pbd_parser (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   item_fire_i,
  input  wire pbd_pkg::pbd_item_t item_i,
  input  wire [16:0]            image_pixels_i,
  output logic                  desc_valid_o,
  output pbd_pkg::pbd_desc_t    desc_o
);
  import pbd_pkg::*;

  parse_phase_e    phase_q, phase_d;
  logic [7:0]      cnt_q, cnt_d;
  logic [PosW-1:0] pos_q, pos_d;

  parse_phase_e    phase_eff;
  logic [7:0]      cnt_eff, cnt_dec;
  logic [PosW-1:0] pos_eff, lim, room;
  logic [PosW:0]   pos_sum;
  logic            skip, emit;
  logic [7:0]      len;

  assign skip = (32'(item_i.channel) >= ChanLimit);
  assign lim  = (32'(image_pixels_i) > PixCap) ? PosW'(PixCap) : image_pixels_i;

  always_comb begin
    phase_eff = (item_i.row_start || item_i.plane_start) ? PH_HEADER : phase_q;
    cnt_eff   = (item_i.row_start || item_i.plane_start) ? 8'd0 : cnt_q;
    pos_eff   = item_i.plane_start ? '0 : pos_q;
    cnt_dec   = (cnt_eff != 8'd0) ? cnt_eff - 8'd1 : 8'd0;
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    emit      = 1'b0;
    len       = 8'd1;
    case (phase_eff)
      PH_LITERAL: begin
        emit    = 1'b1;
        cnt_d   = cnt_dec;
        phase_d = (cnt_dec == 8'd0) ? PH_HEADER : PH_LITERAL;
      end
      PH_REPEAT: begin
        emit    = 1'b1;
        len     = cnt_eff;
        cnt_d   = 8'd0;
        phase_d = PH_HEADER;
      end
      default: begin
        if (item_i.data_byte < HdrNop) begin
          phase_d = PH_LITERAL;
          cnt_d   = item_i.data_byte + 8'd1;
        end else if (item_i.data_byte > HdrNop) begin
          phase_d = PH_REPEAT;
          cnt_d   = 8'(RepeatSub - {1'b0, item_i.data_byte});
        end else begin
          phase_d = PH_HEADER;
          cnt_d   = 8'd0;
        end
      end
    endcase
    pos_sum = {1'b0, pos_eff} + (PosW+1)'(len);
    pos_d   = emit ? (pos_sum[PosW] ? PosMax : pos_sum[PosW-1:0]) : pos_eff;
  end

  always_comb begin
    room                 = lim - pos_eff;
    desc_valid_o         = item_fire_i && !skip && emit && (pos_eff < lim);
    desc_o.value         = item_i.data_byte;
    desc_o.byte_lane     = lane_of_channel(item_i.channel[1:0]);
    desc_o.start_pixel   = pos_eff[15:0];
    desc_o.run_length    = ({9'd0, len} < room) ? len : room[7:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      cnt_q   <= 8'd0;
      pos_q   <= '0;
    end else if (item_fire_i && !skip) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      pos_q   <= pos_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/packbits_planar_to_bgra_decoder_unit.sv =====
// An accepted item is held in the input register and parsed once the result register
//   has room; any descriptor is registered and shown on the master side until taken.
// Throughput: one byte per cycle unless the master side stalls the result register.
// Items that give no descriptor still take one pass through the parse stage.
// Reset (async, active low) empties both registers, sets the parse to header,
//   pixel position to 0 and image_pixels to 65536.
`default_nettype none
module packbits_planar_to_bgra_decoder_unit (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire  [16:0] cfg_wdata_i,    // image_pixels
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [7:0]  s_axis_tdata_i, // data_byte
  input  wire  [5:0]  s_axis_tuser_i, // channel[3:0], row_start[4], plane_start[5]
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o  // value[7:0], byte_lane[9:8],
                                      // start_pixel[25:10], run_length[33:26]
);
  import pbd_pkg::*;

  logic [PosW-1:0] img_q;
  logic            in_vld_q, out_vld_q;
  pbd_item_t       in_q;
  pbd_desc_t       out_q, desc;
  logic            adv, desc_vld;

  // input register drains when the result register has room
  assign adv             = in_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_q <= ImagePixelsRst;
    end else if (cfg_we_i) begin
      img_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_q <= {s_axis_tuser_i, s_axis_tdata_i};
    end
  end

  pbd_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_fire_i    (adv),
    .item_i         (in_q),
    .image_pixels_i (img_q),
    .desc_valid_o   (desc_vld),
    .desc_o         (desc)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (!out_vld_q || m_axis_tready_i) begin
      out_vld_q <= desc_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (desc_vld) begin
      out_q <= desc;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {(DataOW-DescW)'(0), out_q};

endmodule
`default_nettype wire

// ===== rtl/pbd_checker.sv =====
`default_nettype none
module pbd_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        s_axis_tready_o,
  input wire        m_axis_tvalid_o,
  input wire        m_axis_tready_i,
  input wire [39:0] m_axis_tdata_o
);

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("result changed while stalled");

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[33:26] != 8'd0 && m_axis_tdata_o[33:26] <= 8'd128
                         && m_axis_tdata_o[39:34] == 6'd0))
    else $error("run length or padding out of range");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with empty result register");

  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !m_axis_tvalid_o)
    else $error("result valid right after reset");

endmodule

bind packbits_planar_to_bgra_decoder_unit pbd_checker u_pbd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
`default_nettype wire
